FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the AIS payload decoder checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/apfd_pkg.sv
// ---------------------------------------------------------------------------
// AIS payload field decoder package
// Store geometry, field positions, message codes and the result layout.
// ---------------------------------------------------------------------------
package apfd_pkg;

	localparam int STORE_BITS = 256;
	localparam int SLOT_BITS  = 6;
	localparam int SLOTS      = (STORE_BITS + SLOT_BITS - 1) / SLOT_BITS;
	localparam int COUNT_W    = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	localparam int CHAR_BASE   = 48;
	localparam int CHAR_GAP_AT = 40;
	localparam int CHAR_GAP    = 8;

	localparam int ID_POS    = 0;
	localparam int ID_LEN    = 6;
	localparam int MMSI_POS  = 8;
	localparam int MMSI_LEN  = 30;
	localparam int PART_POS  = 38;
	localparam int PART_LEN  = 2;

	localparam int POS_BASE_A = 50;
	localparam int POS_BASE_B = 46;
	localparam int SOG_OFS    = 0;
	localparam int SOG_LEN    = 10;
	localparam int LON_OFS    = 11;
	localparam int LON_LEN    = 28;
	localparam int LAT_OFS    = 39;
	localparam int LAT_LEN    = 27;
	localparam int COG_OFS    = 66;
	localparam int COG_LEN    = 12;

	localparam int NAME_BASE_STATIC = 112;
	localparam int NAME_BASE_T24A   = 40;
	localparam int NAME_CODES       = 20;
	localparam int NAME_HALF_BITS   = 60;
	localparam int NAME_BITS        = 2 * NAME_HALF_BITS;
	localparam int NAME_LEN_W       = 5;

	localparam logic [5:0] MSG_POS_A1   = 6'd1;
	localparam logic [5:0] MSG_POS_A2   = 6'd2;
	localparam logic [5:0] MSG_POS_A3   = 6'd3;
	localparam logic [5:0] MSG_STATIC   = 6'd5;
	localparam logic [5:0] MSG_SAR      = 6'd9;
	localparam logic [5:0] MSG_POS_B    = 6'd18;
	localparam logic [5:0] MSG_STATIC_B = 6'd24;

	localparam logic REG_SOG_LIMIT = 1'b0;
	localparam logic REG_COG_LIMIT = 1'b1;
	localparam logic [9:0]  SOG_LIMIT_RST = 10'd1000;
	localparam logic [11:0] COG_LIMIT_RST = 12'd3600;

	typedef enum logic [2:0] {
		KIND_CLASS_A = 3'd0,
		KIND_SAR     = 3'd1,
		KIND_CLASS_B = 3'd2,
		KIND_STATIC  = 3'd3,
		KIND_T24A    = 3'd4,
		KIND_T24B    = 3'd5,
		KIND_UNSUP   = 3'd6
	} msg_kind_t;

	typedef struct packed {
		logic [NAME_LEN_W-1:0]     name_length;
		logic [NAME_HALF_BITS-1:0] name_second;
		logic [NAME_HALF_BITS-1:0] name_first;
		logic                      cog_ok;
		logic [COG_LEN-1:0]        cog_tenths;
		logic signed [LAT_LEN-1:0] latitude;
		logic signed [LON_LEN-1:0] longitude;
		logic                      sog_ok;
		logic [SOG_LEN-1:0]        sog_tenths;
		logic [MMSI_LEN-1:0]       mmsi;
		logic [ID_LEN-1:0]         msg_id;
	} out_data_t;

	localparam int OUT_W = $bits(out_data_t);

endpackage

FILE: design/ais_payload_field_decoder.sv
// ---------------------------------------------------------------------------
// AIS payload field decoder
// Collects de-armored payload characters and decodes one report per message.
// ---------------------------------------------------------------------------
// Channel  Direction  Signals                         Item
// s_*      in         tvalid tready tdata[7:0] tlast  one payload character
// m_*      out        tvalid tready tdata tuser[2:0]  one decoded report
// cfg_*    in         wr_en index wdata[11:0]         one limit register write
//
// One character is accepted every cycle; throughput is set by the single
// character stage that writes the slot store and decodes on the last one.
// A report is decoded in the character stage and registered when its last character advances.
// Reset clears the slot store, the character count and the valid flags of both pipeline stages.
// The input stalls only while a report waits in the output register and a
// new last character is ready to replace it.
// ---------------------------------------------------------------------------
module ais_payload_field_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] payload_char
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] msg_id, [35:6] mmsi, [45:36] sog_tenths, [46] sog_ok,
	// [74:47] longitude, [101:75] latitude, [113:102] cog_tenths, [114] cog_ok,
	// [174:115] name_first, [234:175] name_second, [239:235] name_length
	output logic [apfd_pkg::OUT_W-1:0] m_tdata,
	output logic [2:0]  m_tuser,   // [2:0] msg_kind
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [11:0] cfg_wdata
);

	logic                           valid_s1;
	logic [7:0]                     char_s1;
	logic                           last_s1;
	logic [apfd_pkg::SLOT_BITS-1:0] slot_q [apfd_pkg::SLOTS];
	logic [apfd_pkg::SLOT_BITS-1:0] slot_nx [apfd_pkg::SLOTS];
	logic [apfd_pkg::COUNT_W-1:0]   count_q;
	logic [9:0]                     sog_limit_q;
	logic [11:0]                    cog_limit_q;
	logic                           m_valid_q;
	apfd_pkg::out_data_t            out_q;
	apfd_pkg::msg_kind_t            kind_q;

	logic                           go;
	logic                           adv;
	logic                           emit;
	logic [apfd_pkg::SLOT_BITS-1:0] dv;
	logic [apfd_pkg::STORE_BITS-1:0] st;
	apfd_pkg::out_data_t            res;
	apfd_pkg::msg_kind_t            kind;
	logic                           has_pos;
	logic                           has_name;
	logic [apfd_pkg::NAME_BITS-1:0] name_bits;
	logic                           found;

	assign go       = !last_s1 || !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || go;
	assign adv      = valid_s1 && go;
	assign emit     = adv && last_s1;

	always_comb begin
		if (char_s1 > 8'(apfd_pkg::CHAR_BASE + apfd_pkg::CHAR_GAP_AT)) begin
			dv = 6'(char_s1 - 8'(apfd_pkg::CHAR_BASE + apfd_pkg::CHAR_GAP));
		end else begin
			dv = 6'(char_s1 - 8'(apfd_pkg::CHAR_BASE));
		end
	end

	always_comb begin
		st = '0;
		for (int k = 0; k < apfd_pkg::SLOTS; k++) begin
			slot_nx[k] = (int'(count_q) == k) ? dv : slot_q[k];
			for (int b = 0; b < apfd_pkg::SLOT_BITS; b++) begin
				if (k * apfd_pkg::SLOT_BITS + b < apfd_pkg::STORE_BITS) begin
					st[apfd_pkg::STORE_BITS - 1 - (k * apfd_pkg::SLOT_BITS + b)] =
						slot_nx[k][apfd_pkg::SLOT_BITS - 1 - b];
				end
			end
		end
	end

	always_comb begin
		res        = '0;
		has_pos    = 1'b0;
		has_name   = 1'b0;
		name_bits  = '0;
		found      = 1'b0;
		res.msg_id = st[apfd_pkg::STORE_BITS-1-apfd_pkg::ID_POS -: apfd_pkg::ID_LEN];
		res.mmsi   = st[apfd_pkg::STORE_BITS-1-apfd_pkg::MMSI_POS -: apfd_pkg::MMSI_LEN];

		unique case (res.msg_id) inside
			apfd_pkg::MSG_POS_A1, apfd_pkg::MSG_POS_A2, apfd_pkg::MSG_POS_A3: begin
				kind    = apfd_pkg::KIND_CLASS_A;
				has_pos = 1'b1;
			end
			apfd_pkg::MSG_SAR: begin
				kind    = apfd_pkg::KIND_SAR;
				has_pos = 1'b1;
			end
			apfd_pkg::MSG_POS_B: begin
				kind    = apfd_pkg::KIND_CLASS_B;
				has_pos = 1'b1;
			end
			apfd_pkg::MSG_STATIC: begin
				kind      = apfd_pkg::KIND_STATIC;
				has_name  = 1'b1;
				name_bits = st[apfd_pkg::STORE_BITS-1-apfd_pkg::NAME_BASE_STATIC
					-: apfd_pkg::NAME_BITS];
			end
			apfd_pkg::MSG_STATIC_B: begin
				if (st[apfd_pkg::STORE_BITS-1-apfd_pkg::PART_POS -: apfd_pkg::PART_LEN]
						== 2'b00) begin
					kind      = apfd_pkg::KIND_T24A;
					has_name  = 1'b1;
					name_bits = st[apfd_pkg::STORE_BITS-1-apfd_pkg::NAME_BASE_T24A
						-: apfd_pkg::NAME_BITS];
				end else begin
					kind = apfd_pkg::KIND_T24B;
				end
			end
			default: begin
				kind = apfd_pkg::KIND_UNSUP;
			end
		endcase

		if (has_pos) begin
			if (kind == apfd_pkg::KIND_CLASS_B) begin
				res.sog_tenths = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_B
					-apfd_pkg::SOG_OFS -: apfd_pkg::SOG_LEN];
				res.longitude  = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_B
					-apfd_pkg::LON_OFS -: apfd_pkg::LON_LEN];
				res.latitude   = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_B
					-apfd_pkg::LAT_OFS -: apfd_pkg::LAT_LEN];
				res.cog_tenths = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_B
					-apfd_pkg::COG_OFS -: apfd_pkg::COG_LEN];
			end else begin
				res.sog_tenths = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_A
					-apfd_pkg::SOG_OFS -: apfd_pkg::SOG_LEN];
				res.longitude  = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_A
					-apfd_pkg::LON_OFS -: apfd_pkg::LON_LEN];
				res.latitude   = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_A
					-apfd_pkg::LAT_OFS -: apfd_pkg::LAT_LEN];
				res.cog_tenths = st[apfd_pkg::STORE_BITS-1-apfd_pkg::POS_BASE_A
					-apfd_pkg::COG_OFS -: apfd_pkg::COG_LEN];
			end
			res.sog_ok = (res.sog_tenths < sog_limit_q);
			res.cog_ok = (res.cog_tenths <= cog_limit_q);
		end

		if (has_name) begin
			res.name_first  = name_bits[apfd_pkg::NAME_BITS-1 -: apfd_pkg::NAME_HALF_BITS];
			res.name_second = name_bits[apfd_pkg::NAME_HALF_BITS-1:0];
			res.name_length = apfd_pkg::NAME_LEN_W'(apfd_pkg::NAME_CODES);
			for (int k = 0; k < apfd_pkg::NAME_CODES; k++) begin
				if (!found && name_bits[apfd_pkg::NAME_BITS - 1 - apfd_pkg::SLOT_BITS * k
						-: apfd_pkg::SLOT_BITS] == '0) begin
					found           = 1'b1;
					res.name_length = apfd_pkg::NAME_LEN_W'(k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < apfd_pkg::SLOTS; k++) begin
				slot_q[k] <= '0;
			end
		end else if (adv) begin
			if (last_s1) begin
				count_q <= '0;
				for (int k = 0; k < apfd_pkg::SLOTS; k++) begin
					slot_q[k] <= '0;
				end
			end else if (count_q < apfd_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
				for (int k = 0; k < apfd_pkg::SLOTS; k++) begin
					if (int'(count_q) == k) begin
						slot_q[k] <= dv;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sog_limit_q <= apfd_pkg::SOG_LIMIT_RST;
			cog_limit_q <= apfd_pkg::COG_LIMIT_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == apfd_pkg::REG_SOG_LIMIT) begin
				sog_limit_q <= cfg_wdata[9:0];
			end else begin
				cog_limit_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q  <= res;
			kind_q <= kind;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = kind_q;

endmodule

FILE: design/apfd_checker.sv
// ---------------------------------------------------------------------------
// AIS payload field decoder checker
// Port-level checks on report holding, on the fields each kind leaves zero and on name length.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apfd_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [apfd_pkg::OUT_W-1:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic kind_pos;
	logic kind_name;

	assign kind_pos  = (m_tuser == apfd_pkg::KIND_CLASS_A) || (m_tuser == apfd_pkg::KIND_SAR)
		|| (m_tuser == apfd_pkg::KIND_CLASS_B);
	assign kind_name = (m_tuser == apfd_pkg::KIND_STATIC) || (m_tuser == apfd_pkg::KIND_T24A);

	`ASSERT_NEXT(a_report_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled report changed")

	`ASSERT_SAME(a_pos_zero, clk, arst_n, m_tvalid && !kind_pos, m_tdata[114:36] == '0, "Position fields set on a kind without position")

	`ASSERT_SAME(a_name_zero, clk, arst_n, m_tvalid && !kind_name, m_tdata[239:115] == '0, "Name fields set on a kind without name")

	`ASSERT_SAME(a_name_len, clk, arst_n, m_tvalid && kind_name, m_tdata[239:235] <= 5'd20, "Name length above twenty")

endmodule

bind ais_payload_field_decoder apfd_port_checks u_apfd_port_checks (.*);
